[hdl/qtg_pkg.sv]
// Shared types, constants and arithmetic helpers of the quintic trajectory generator.
package qtg_pkg;

    localparam int COEF_PER_JOINT = 6;
    localparam int WORD_W         = 64;

    localparam logic        OP_PLAN = 1'b0;
    localparam logic        OP_EVAL = 1'b1;

    localparam logic [31:0] DURATION_RESET = 32'd327680;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic        [31:0] b;
        logic        [5:0]  sh;
    } t_mul_req;

    typedef struct packed {
        logic               start;
        logic signed [63:0] a;
        logic        [32:0] d;
        logic        [5:0]  sh;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
    } t_unit_rsp;

    // Saturating 64-bit add or subtract.
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic sub);
        logic signed [64:0] s;
        if (sub) begin
            s = {a[63], a} - {b[63], b};
        end else begin
            s = {a[63], a} + {b[63], b};
        end
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    // Applies a sign to a magnitude and saturates to the signed 64-bit range.
    function automatic logic signed [63:0] sat_mag(input logic [63:0] mag,
                                                   input logic ovf,
                                                   input logic neg);
        if (ovf || mag[63]) begin
            return neg ? S64_MIN : S64_MAX;
        end
        return neg ? -signed'(mag) : signed'(mag);
    endfunction

    // Factor that turns coefficient i into its term of derivative order m.
    function automatic logic [4:0] coef_scale(input logic [2:0] i, input logic [1:0] m);
        logic [4:0] f;
        case (m)
            2'd0:    f = 5'd1;
            2'd1:    f = {2'b0, i};
            default: f = 5'({2'b0, i} * ({2'b0, i} - 5'd1));
        endcase
        return f;
    endfunction

endpackage

[hdl/qtg_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module qtg_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 36
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

[hdl/qtg_mul.sv]
// Multi-cycle signed 64 x unsigned 32 multiplier with rounded right shift and saturation.
module qtg_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qtg_pkg::t_mul_req   i_req,
    output qtg_pkg::t_unit_rsp  o_rsp
);
    import qtg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_LO, S_HI, S_SUM, S_FIN} t_state;

    t_state       r_state;
    logic [63:0]  r_mag;
    logic         r_neg;
    logic [31:0]  r_b;
    logic [5:0]   r_sh;
    logic [63:0]  r_plo;
    logic [63:0]  r_phi;
    logic [96:0]  r_sum;
    t_unit_rsp    r_rsp;

    logic [31:0]  w_op;
    logic [63:0]  w_prod;
    logic [96:0]  w_half;
    logic [96:0]  w_shifted;
    logic         w_ovf;

    // One 32 x 32 multiplier serves both halves of the 64-bit operand.
    assign w_op      = (r_state == S_LO) ? r_mag[31:0] : r_mag[63:32];
    assign w_prod    = w_op * r_b;
    assign w_half    = (r_sh == 6'd0) ? 97'd0 : (97'd1 << (r_sh - 6'd1));
    assign w_shifted = r_sum >> r_sh;
    assign w_ovf     = |w_shifted[96:64];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_mag   <= i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
                        r_neg   <= i_req.a[63];
                        r_b     <= i_req.b;
                        r_sh    <= i_req.sh;
                        r_state <= S_LO;
                    end
                end
                S_LO: begin
                    r_plo   <= w_prod;
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_phi   <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= {1'b0, r_phi, 32'b0} + 97'(r_plo) + w_half;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_rsp.value <= sat_mag(w_shifted[63:0], w_ovf, r_neg);
                    r_rsp.done  <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp = r_rsp;
endmodule

[hdl/qtg_div.sv]
// Bit-serial long divider: (|a| << sh) / d, rounded half away from zero, saturated.
module qtg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qtg_pkg::t_div_req   i_req,
    output qtg_pkg::t_unit_rsp  o_rsp
);
    import qtg_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_RND, S_FIN} t_state;

    t_state        r_state;
    logic [127:0]  r_num;
    logic [32:0]   r_rem;
    logic [32:0]   r_d;
    logic [63:0]   r_q;
    logic          r_ovf;
    logic          r_neg;
    logic [6:0]    r_cnt;
    t_unit_rsp     r_rsp;

    logic [63:0]   w_amag;
    logic [33:0]   w_rr;
    logic          w_ge;
    logic [33:0]   w_diff;
    logic          w_up;
    logic [64:0]   w_inc;

    // The magnitude is held unsigned so that widening it fills with zeros.
    assign w_amag = i_req.a[63] ? 64'(-i_req.a) : 64'(i_req.a);
    assign w_rr   = {r_rem, r_num[127]};
    assign w_ge   = w_rr >= {1'b0, r_d};
    assign w_diff = w_rr - {1'b0, r_d};
    // Round up when twice the remainder reaches the divisor.
    assign w_up   = {r_rem, 1'b0} >= {1'b0, r_d};
    assign w_inc  = {1'b0, r_q} + 65'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_num   <= 128'(w_amag) << i_req.sh;
                        r_neg   <= i_req.a[63];
                        r_d     <= i_req.d;
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_ovf   <= 1'b0;
                        r_cnt   <= 7'd127;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_num <= {r_num[126:0], 1'b0};
                    r_rem <= w_ge ? w_diff[32:0] : w_rr[32:0];
                    r_q   <= {r_q[62:0], w_ge};
                    // A quotient bit leaving the top means the result cannot fit.
                    r_ovf <= r_ovf | r_q[63];
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd0) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    if (w_up) begin
                        r_q   <= w_inc[63:0];
                        r_ovf <= r_ovf | w_inc[64];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_rsp.value <= sat_mag(r_q, r_ovf, r_neg);
                    r_rsp.done  <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp = r_rsp;
endmodule

[hdl/quintic_trajectory_generator.sv]
// Top level: sequencer around the coefficient RAM, the shared multiplier and the divider.
//
// Input stream (s_axis): tuser selects the operation, 0 plans one joint, 1 evaluates all.
// A plan transfer computes the joint's six quintic coefficients over the current move
// duration and writes them to the coefficient RAM; it produces no output. A plan for a
// joint at or above JOINT_COUNT is dropped. An evaluate transfer produces JOINT_COUNT
// output transfers (m_axis), joint 0 first, tlast on the last joint, tuser set when the
// time lies beyond the move duration.
// One item is worked at a time; s_axis_tready is high only while the sequencer is idle.
// A plan's run time is set by twelve bit-serial divisions, an evaluate's by thirty passes
// through the shared multiplier per joint.
// The result register lets the sequencer continue with the next joint while a result
// waits; a stalled receiver holds the sequencer at the following joint's hand-off.
// Reset returns to idle, sets the duration to 5.0 s and marks every joint unplanned,
// so unplanned joints read as zero coefficients. The user must write the duration through
// i_cfg_wr_en / i_cfg_wr_data only while no item is in progress; the block does not enforce it.
module quintic_trajectory_generator #(
    parameter int JOINT_COUNT   = 6,
    parameter int FRACTION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [31:0]   i_cfg_wr_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // tdata from bit 0: joint_index[3], eval_time[32], start_position[32],
    // start_velocity[32], start_acceleration[32], end_position[32],
    // end_velocity[32], end_acceleration[32], zero padding[5]
    input  logic [231:0]  s_axis_tdata,
    // tuser: op[1]
    input  logic          s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // tdata from bit 0: out_joint[3], position[32], velocity[32], acceleration[32],
    // zero padding[5]
    output logic [103:0]  m_axis_tdata,
    // tuser: past_end[1]
    output logic          m_axis_tuser,
    output logic          m_axis_tlast
);
    import qtg_pkg::*;

    localparam int DEPTH = JOINT_COUNT * COEF_PER_JOINT;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam logic [5:0] SH_ONE = 6'(FRACTION_BITS);
    localparam logic [5:0] SH_TWO = 6'(2 * FRACTION_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_P_LOW, S_P_LOAD, S_P_M1, S_P_M2, S_P_M3, S_P_DIV, S_P_WR,
        S_E_RD, S_E_SCL, S_E_SCLW, S_E_STEPW, S_E_OUTW, S_E_EMIT
    } t_state;

    t_state                 r_state;
    logic [31:0]            r_duration;
    logic [JW-1:0]          r_j;
    logic [2:0]             r_k;
    logic [1:0]             r_m;
    logic [2:0]             r_dcnt;
    logic                   r_first;
    logic signed [63:0]     r_acc;
    logic signed [63:0]     r_p;
    logic signed [31:0]     r_ps, r_vs, r_as, r_pf, r_vf, r_af;
    logic [31:0]            r_time;
    logic                   r_past;
    logic [31:0]            r_pos, r_vel, r_acl;
    logic [JOINT_COUNT-1:0] r_valid;
    logic                   r_rd_valid;
    t_mul_req               r_mreq;
    t_div_req               r_dreq;
    logic                   r_o_tvalid;
    logic [2:0]             r_o_joint;
    logic [31:0]            r_o_pos, r_o_vel, r_o_acl;
    logic                   r_o_past;
    logic                   r_o_last;

    t_unit_rsp              w_mrsp, w_drsp;
    logic [31:0]            w_tl;
    logic                   w_in_acc;
    logic signed [63:0]     w_dp, w_x, w_y, w_z;
    logic                   w_sub;
    logic                   w_ram_we, w_ram_re;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [63:0]            w_wdata, w_rdata;
    logic signed [63:0]     w_coef;
    logic [2:0]             w_rk;
    logic signed [63:0]     w_eval_acc;
    logic [31:0]            w_clamped;
    logic                   w_out_free;

    assign w_tl     = (r_duration == 32'd0) ? 32'd1 : r_duration;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);

    // Numerator terms of the three upper coefficients: X + or - Y*T + or - Z*T*T.
    assign w_dp = 64'(r_pf) - 64'(r_ps);
    always_comb begin
        case (r_k)
            3'd3: begin
                w_x   = 64'sd20 * w_dp;
                w_y   = 64'sd8 * 64'(r_vf) + 64'sd12 * 64'(r_vs);
                w_z   = 64'sd3 * 64'(r_as) - 64'(r_af);
                w_sub = 1'b1;
            end
            3'd4: begin
                w_x   = -(64'sd30 * w_dp);
                w_y   = 64'sd14 * 64'(r_vf) + 64'sd16 * 64'(r_vs);
                w_z   = 64'sd3 * 64'(r_as) - 64'sd2 * 64'(r_af);
                w_sub = 1'b0;
            end
            default: begin
                w_x   = 64'sd12 * w_dp;
                w_y   = 64'sd6 * 64'(r_vf) + 64'sd6 * 64'(r_vs);
                w_z   = 64'(r_as) - 64'(r_af);
                w_sub = 1'b1;
            end
        endcase
    end

    assign w_coef     = r_rd_valid ? signed'(w_rdata) : 64'sd0;
    assign w_rk       = r_k - 3'd1;
    assign w_eval_acc = r_first ? w_mrsp.value : sat_add(r_p, w_mrsp.value, 1'b0);
    assign w_out_free = !r_o_tvalid || m_axis_tready;

    always_comb begin
        if (w_mrsp.value > 64'sd2147483647) begin
            w_clamped = 32'h7FFF_FFFF;
        end else if (w_mrsp.value < -64'sd2147483648) begin
            w_clamped = 32'h8000_0000;
        end else begin
            w_clamped = w_mrsp.value[31:0];
        end
    end

    // RAM ports follow the state directly so read data is ready in the next state.
    always_comb begin
        w_ram_we = 1'b0;
        w_ram_re = 1'b0;
        w_waddr  = AW'(r_j * COEF_PER_JOINT + r_k);
        w_raddr  = AW'(r_j * COEF_PER_JOINT + r_k);
        w_wdata  = r_acc;
        unique case (r_state)
            S_P_LOW: begin
                w_ram_we = 1'b1;
                case (r_k)
                    3'd0:    w_wdata = 64'(r_ps) <<< FRACTION_BITS;
                    3'd1:    w_wdata = 64'(r_vs) <<< FRACTION_BITS;
                    default: w_wdata = 64'(r_as) <<< (FRACTION_BITS - 1);
                endcase
            end
            S_P_WR: w_ram_we = 1'b1;
            S_E_RD: w_ram_re = 1'b1;
            S_E_SCLW: begin
                if (w_mrsp.done && r_k != {1'b0, r_m}) begin
                    w_ram_re = 1'b1;
                    w_raddr  = AW'(r_j * COEF_PER_JOINT + w_rk);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= DURATION_RESET;
        end else if (i_cfg_wr_en) begin
            r_duration <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
            r_o_tvalid   <= 1'b0;
        end else begin
            r_mreq.start <= 1'b0;
            r_dreq.start <= 1'b0;
            if (r_o_tvalid && m_axis_tready) begin
                r_o_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_time <= s_axis_tdata[34:3];
                        r_ps   <= s_axis_tdata[66:35];
                        r_vs   <= s_axis_tdata[98:67];
                        r_as   <= s_axis_tdata[130:99];
                        r_pf   <= s_axis_tdata[162:131];
                        r_vf   <= s_axis_tdata[194:163];
                        r_af   <= s_axis_tdata[226:195];
                        r_past <= s_axis_tdata[34:3] > w_tl;
                        if (s_axis_tuser == OP_EVAL) begin
                            r_j     <= '0;
                            r_m     <= 2'd0;
                            r_k     <= 3'd5;
                            r_first <= 1'b1;
                            r_state <= S_E_RD;
                        end else if (32'(s_axis_tdata[2:0]) < JOINT_COUNT) begin
                            r_j     <= JW'(s_axis_tdata[2:0]);
                            r_k     <= 3'd0;
                            r_state <= S_P_LOW;
                        end
                    end
                end
                S_P_LOW: begin
                    r_valid[r_j] <= 1'b1;
                    r_k          <= r_k + 3'd1;
                    if (r_k == 3'd2) begin
                        r_state <= S_P_LOAD;
                    end
                end
                S_P_LOAD: begin
                    r_acc   <= w_x;
                    r_mreq  <= '{start: 1'b1, a: w_y, b: w_tl, sh: SH_ONE};
                    r_state <= S_P_M1;
                end
                S_P_M1: begin
                    if (w_mrsp.done) begin
                        r_acc   <= sat_add(r_acc, w_mrsp.value, w_sub);
                        r_mreq  <= '{start: 1'b1, a: w_z, b: w_tl, sh: SH_ONE};
                        r_state <= S_P_M2;
                    end
                end
                S_P_M2: begin
                    if (w_mrsp.done) begin
                        r_mreq  <= '{start: 1'b1, a: w_mrsp.value, b: w_tl, sh: SH_ONE};
                        r_state <= S_P_M3;
                    end
                end
                S_P_M3: begin
                    if (w_mrsp.done) begin
                        r_dreq  <= '{start: 1'b1, a: sat_add(r_acc, w_mrsp.value, w_sub),
                                     d: {1'b0, w_tl}, sh: SH_ONE};
                        r_dcnt  <= 3'd1;
                        r_state <= S_P_DIV;
                    end
                end
                S_P_DIV: begin
                    // Divide by T for all but the last step, which divides by 2T.
                    if (w_drsp.done) begin
                        if (r_dcnt == r_k) begin
                            r_acc   <= w_drsp.value;
                            r_state <= S_P_WR;
                        end else begin
                            r_dcnt <= r_dcnt + 3'd1;
                            if (r_dcnt + 3'd1 == r_k) begin
                                r_dreq <= '{start: 1'b1, a: w_drsp.value,
                                            d: {w_tl, 1'b0}, sh: SH_TWO};
                            end else begin
                                r_dreq <= '{start: 1'b1, a: w_drsp.value,
                                            d: {1'b0, w_tl}, sh: SH_ONE};
                            end
                        end
                    end
                end
                S_P_WR: begin
                    if (r_k == 3'd5) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_P_LOAD;
                    end
                end
                S_E_RD: begin
                    r_rd_valid <= r_valid[r_j];
                    r_state    <= S_E_SCL;
                end
                S_E_SCL: begin
                    r_mreq  <= '{start: 1'b1, a: w_coef, b: 32'(coef_scale(r_k, r_m)),
                                 sh: 6'd0};
                    r_state <= S_E_SCLW;
                end
                S_E_SCLW: begin
                    if (w_mrsp.done) begin
                        r_acc   <= w_eval_acc;
                        r_first <= 1'b0;
                        if (r_k == {1'b0, r_m}) begin
                            r_mreq  <= '{start: 1'b1, a: w_eval_acc, b: 32'd1, sh: SH_ONE};
                            r_state <= S_E_OUTW;
                        end else begin
                            r_k        <= w_rk;
                            r_rd_valid <= r_valid[r_j];
                            r_mreq     <= '{start: 1'b1, a: w_eval_acc, b: r_time,
                                            sh: SH_ONE};
                            r_state    <= S_E_STEPW;
                        end
                    end
                end
                S_E_STEPW: begin
                    if (w_mrsp.done) begin
                        r_p     <= w_mrsp.value;
                        r_mreq  <= '{start: 1'b1, a: w_coef,
                                     b: 32'(coef_scale(r_k, r_m)), sh: 6'd0};
                        r_state <= S_E_SCLW;
                    end
                end
                S_E_OUTW: begin
                    if (w_mrsp.done) begin
                        case (r_m)
                            2'd0:    r_pos <= w_clamped;
                            2'd1:    r_vel <= w_clamped;
                            default: r_acl <= w_clamped;
                        endcase
                        if (r_m == 2'd2) begin
                            r_state <= S_E_EMIT;
                        end else begin
                            r_m     <= r_m + 2'd1;
                            r_k     <= 3'd5;
                            r_first <= 1'b1;
                            r_state <= S_E_RD;
                        end
                    end
                end
                S_E_EMIT: begin
                    if (w_out_free) begin
                        r_o_tvalid <= 1'b1;
                        r_o_joint  <= 3'(r_j);
                        r_o_pos    <= r_pos;
                        r_o_vel    <= r_vel;
                        r_o_acl    <= r_acl;
                        r_o_past   <= r_past;
                        r_o_last   <= (32'(r_j) == JOINT_COUNT - 1);
                        if (32'(r_j) == JOINT_COUNT - 1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_m     <= 2'd0;
                            r_k     <= 3'd5;
                            r_first <= 1'b1;
                            r_state <= S_E_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    qtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    qtg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_rsp   (w_mrsp)
    );

    qtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_rsp   (w_drsp)
    );

    assign m_axis_tvalid = r_o_tvalid;
    assign m_axis_tdata  = {5'b0, r_o_acl, r_o_vel, r_o_pos, r_o_joint};
    assign m_axis_tuser  = r_o_past;
    assign m_axis_tlast  = r_o_last;

`ifndef SYNTHESIS
    a_mul_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mrsp.done |-> (r_state == S_P_M1 || r_state == S_P_M2 || r_state == S_P_M3 ||
                         r_state == S_E_SCLW || r_state == S_E_STEPW ||
                         r_state == S_E_OUTW))
        else $error("multiplier result arrived outside a wait state");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_drsp.done |-> r_state == S_P_DIV)
        else $error("divider result arrived outside the divide state");

    a_last_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> 32'(m_axis_tdata[2:0]) == JOINT_COUNT - 1)
        else $error("tlast on a joint other than the last");

    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mrsp.done && w_drsp.done))
        else $error("multiplier and divider finished together");
`endif
endmodule
